>>> sv/elcc_pkg.sv
package elcc_pkg;

  localparam int FLOOR_COUNT = 5;
  localparam int FLOOR_W     = 3;
  localparam int TICK_W      = 8;
  localparam int PEND_W      = 3;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [TICK_W-1:0] MOVE_TICKS_RST  = 8'd5;
  localparam logic [TICK_W-1:0] DWELL_TICKS_RST = 8'd10;

  // Register index, taken from the word address bit.
  localparam logic REG_MOVE_TICKS  = 1'b0;
  localparam logic REG_DWELL_TICKS = 1'b1;

  typedef logic [FLOOR_COUNT-1:0] floor_mask_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_MOVING  = 2'd1,
    MODE_STOPPED = 2'd2
  } mode_t;

  typedef struct packed {
    floor_mask_t         hall_calls;
    floor_mask_t         car_calls;
    logic [FLOOR_W-1:0]  floor_now;
    logic                dir_down;
    mode_t               mode_now;
    logic [TICK_W-1:0]   tick_count;
  } ctrl_state_t;

  typedef struct packed {
    logic [TICK_W-1:0] move_ticks;
    logic [TICK_W-1:0] dwell_ticks;
  } cfg_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] car_floor;
    logic               going_down;
    logic [1:0]         car_mode;
    logic               arrived;
    logic [PEND_W-1:0]  hall_pending;
    logic [PEND_W-1:0]  car_pending;
  } result_t;

  // One-hot floor select; floors outside 1..FLOOR_COUNT give an empty mask.
  function automatic floor_mask_t floor_bit(input logic [FLOOR_W-1:0] f);
    floor_mask_t m;
    m = '0;
    for (int i = 0; i < FLOOR_COUNT; i++) begin
      m[i] = (f == FLOOR_W'(i + 1));
    end
    return m;
  endfunction

  function automatic logic [PEND_W-1:0] count_calls(input floor_mask_t m);
    logic [PEND_W-1:0] n;
    n = '0;
    for (int i = 0; i < FLOOR_COUNT; i++) begin
      n = n + PEND_W'(m[i]);
    end
    return n;
  endfunction

endpackage

>>> sv/elcc_step.sv
module elcc_step (
  input  elcc_pkg::ctrl_state_t            cur,
  input  elcc_pkg::cfg_t                   cfg,
  input  logic                             req_type,
  input  logic [elcc_pkg::FLOOR_W-1:0]     hall_floor,
  input  logic [elcc_pkg::FLOOR_W-1:0]     boarding_dest,
  output elcc_pkg::ctrl_state_t            nxt,
  output logic                             arrived
);

  elcc_pkg::floor_mask_t        cbit;
  elcc_pkg::floor_mask_t        hall_rec;
  elcc_pkg::floor_mask_t        calls;
  elcc_pkg::floor_mask_t        stop_bit;
  logic                         above;
  logic                         below;
  logic                         dir_new;
  logic [elcc_pkg::TICK_W-1:0]  tick_inc;
  logic [elcc_pkg::FLOOR_W-1:0] floor_step;

  assign cbit     = req_type ? elcc_pkg::floor_bit(hall_floor) : '0;
  assign tick_inc = cur.tick_count + 1'b1;

  // Calls seen by the sweep decision: a call in this word is recorded first,
  // except in the stopped mode, where the decision is only taken on a tick.
  always_comb begin
    hall_rec = cur.hall_calls;
    if (cur.mode_now != elcc_pkg::MODE_STOPPED) begin
      hall_rec = cur.hall_calls | cbit;
    end
    calls = hall_rec | cur.car_calls;
  end

  always_comb begin
    above = 1'b0;
    below = 1'b0;
    for (int i = 0; i < elcc_pkg::FLOOR_COUNT; i++) begin
      above = above | (calls[i] && (elcc_pkg::FLOOR_W'(i + 1) > cur.floor_now));
      below = below | (calls[i] && (elcc_pkg::FLOOR_W'(i + 1) < cur.floor_now));
    end
  end

  // Sweep rule: turn at the end floors, else keep going while calls lie ahead.
  always_comb begin
    priority if (cur.floor_now <= elcc_pkg::FLOOR_W'(1) && cur.dir_down) begin
      dir_new = 1'b0;
    end else if (cur.floor_now >= elcc_pkg::FLOOR_W'(elcc_pkg::FLOOR_COUNT)
                 && !cur.dir_down) begin
      dir_new = 1'b1;
    end else if (!cur.dir_down) begin
      dir_new = !above;
    end else begin
      dir_new = below;
    end
  end

  always_comb begin
    floor_step = cur.floor_now;
    if (dir_new) begin
      if (cur.floor_now > elcc_pkg::FLOOR_W'(1)) begin
        floor_step = cur.floor_now - 1'b1;
      end
    end else if (cur.floor_now < elcc_pkg::FLOOR_W'(elcc_pkg::FLOOR_COUNT)) begin
      floor_step = cur.floor_now + 1'b1;
    end
  end

  assign stop_bit = elcc_pkg::floor_bit(floor_step);

  always_comb begin
    nxt     = cur;
    arrived = 1'b0;
    unique case (cur.mode_now)
      elcc_pkg::MODE_MOVING: begin
        nxt.hall_calls = hall_rec;
        nxt.tick_count = tick_inc;
        if (tick_inc == cfg.move_ticks) begin
          nxt.tick_count = '0;
          nxt.dir_down   = dir_new;
          nxt.floor_now  = floor_step;
          if ((calls & stop_bit) != '0) begin
            // Serve the floor: drop its calls, a boarding passenger adds a car call.
            arrived       = 1'b1;
            nxt.mode_now  = elcc_pkg::MODE_STOPPED;
            nxt.car_calls = cur.car_calls & ~stop_bit;
            if ((hall_rec & stop_bit) != '0) begin
              nxt.hall_calls = hall_rec & ~stop_bit;
              nxt.car_calls  = (cur.car_calls & ~stop_bit)
                               | elcc_pkg::floor_bit(boarding_dest);
            end
          end
        end
      end
      elcc_pkg::MODE_STOPPED: begin
        if (req_type) begin
          if (hall_floor != cur.floor_now) begin
            nxt.hall_calls = cur.hall_calls | cbit;
          end
        end else if (cur.tick_count == cfg.dwell_ticks) begin
          nxt.dir_down   = dir_new;
          nxt.mode_now   = (calls != '0) ? elcc_pkg::MODE_MOVING : elcc_pkg::MODE_IDLE;
          nxt.tick_count = '0;
        end else begin
          nxt.tick_count = tick_inc;
        end
      end
      default: begin
        nxt.mode_now = elcc_pkg::MODE_IDLE;
        if (cbit != '0 && hall_floor != cur.floor_now) begin
          nxt.hall_calls = hall_rec;
          nxt.dir_down   = dir_new;
          nxt.mode_now   = elcc_pkg::MODE_MOVING;
          nxt.tick_count = '0;
        end
      end
    endcase
  end

endmodule

>>> sv/elevator_collective_controller_core.sv
// Collective (sweep) controller for a five-floor lift car.
// Input channel: one word per event (in_valid / in_stall). req_type 0 is a
// time tick, 1 a hall call at hall_floor; boarding_dest names the floor that
// a passenger boarding at this step will travel to.
// Output channel: one result word per input word (out_valid / out_stall),
// carrying car position, direction, mode, an arrival flag and call counts.
// The result of a word is registered in the output register, or in the skid
// register while the receiver stalls, as the word is accepted. Throughput: one
// word per cycle while in_stall is low; the next-state logic is a single pass
// over the 5-bit call masks between the state registers. When the receiver
// stalls, the output register holds its word and a skid register takes one
// more; in_stall rises only while the skid is full. Reset: no calls, car at
// floor 1 heading up, idle, move_ticks 5, dwell_ticks 10, both channels empty.
// Configuration: APB, move_ticks at 0x0 and dwell_ticks at 0x4 (low 8 bits).
// Write the registers only while no word is in flight.
module elevator_collective_controller_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic [elcc_pkg::FLOOR_W-1:0]        hall_floor,
  input  logic [elcc_pkg::FLOOR_W-1:0]        boarding_dest,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [elcc_pkg::FLOOR_W-1:0]        car_floor,
  output logic                                going_down,
  output logic [1:0]                          car_mode,
  output logic                                arrived,
  output logic [elcc_pkg::PEND_W-1:0]         hall_pending,
  output logic [elcc_pkg::PEND_W-1:0]         car_pending,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [elcc_pkg::ADDR_W-1:0]         paddr,
  input  logic [elcc_pkg::DATA_W-1:0]         pwdata,
  output logic [elcc_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  elcc_pkg::cfg_t        cfg;
  elcc_pkg::ctrl_state_t state;
  elcc_pkg::ctrl_state_t state_next;
  logic                  step_arrived;
  elcc_pkg::result_t     res_next;
  elcc_pkg::result_t     out_res;
  elcc_pkg::result_t     skid_res;
  logic                  skid_valid;
  logic                  in_acc;
  logic                  out_free;
  logic                  cfg_wr;

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_ticks  <= elcc_pkg::MOVE_TICKS_RST;
      cfg.dwell_ticks <= elcc_pkg::DWELL_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        elcc_pkg::REG_MOVE_TICKS:  cfg.move_ticks  <= pwdata[elcc_pkg::TICK_W-1:0];
        elcc_pkg::REG_DWELL_TICKS: cfg.dwell_ticks <= pwdata[elcc_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      elcc_pkg::REG_MOVE_TICKS:  prdata[elcc_pkg::TICK_W-1:0] = cfg.move_ticks;
      elcc_pkg::REG_DWELL_TICKS: prdata[elcc_pkg::TICK_W-1:0] = cfg.dwell_ticks;
      default: ;
    endcase
  end

  // ---- handshake ----
  // Accept while the skid is empty; the skid drains into the output register.
  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  // ---- controller state ----
  elcc_step u_step (
    .cur           (state),
    .cfg           (cfg),
    .req_type      (req_type),
    .hall_floor    (hall_floor),
    .boarding_dest (boarding_dest),
    .nxt           (state_next),
    .arrived       (step_arrived)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.hall_calls <= '0;
      state.car_calls  <= '0;
      state.floor_now  <= elcc_pkg::FLOOR_W'(1);
      state.dir_down   <= 1'b0;
      state.mode_now   <= elcc_pkg::MODE_IDLE;
      state.tick_count <= '0;
    end else if (in_acc) begin
      state <= state_next;
    end
  end

  // Result word for the state just computed.
  always_comb begin
    res_next.car_floor    = state_next.floor_now;
    res_next.going_down   = state_next.dir_down;
    res_next.car_mode     = state_next.mode_now;
    res_next.arrived      = step_arrived;
    res_next.hall_pending = elcc_pkg::count_calls(state_next.hall_calls);
    res_next.car_pending  = elcc_pkg::count_calls(state_next.car_calls);
  end

  // ---- output register and skid ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_acc;
      skid_valid <= 1'b0;
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res_next;
    end else if (in_acc) begin
      skid_res <= res_next;
    end
  end

  assign car_floor    = out_res.car_floor;
  assign going_down   = out_res.going_down;
  assign car_mode     = out_res.car_mode;
  assign arrived      = out_res.arrived;
  assign hall_pending = out_res.hall_pending;
  assign car_pending  = out_res.car_pending;

endmodule

>>> sim/elevator_collective_controller_core_test.sv
`timescale 1ns / 1ps

module elevator_collective_controller_core_test;
  import elcc_pkg::*;

  // Clock, reset and the stimulus side of both channels.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid      = 1'b0;
  logic                req_type      = 1'b0;
  logic [FLOOR_W-1:0]  hall_floor    = '0;
  logic [FLOOR_W-1:0]  boarding_dest = '0;
  logic                out_stall     = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ADDR_W-1:0]   paddr         = '0;
  logic [DATA_W-1:0]   pwdata        = '0;

  logic                in_stall;
  logic                out_valid;
  logic [FLOOR_W-1:0]  car_floor;
  logic                going_down;
  logic [1:0]          car_mode;
  logic                arrived;
  logic [PEND_W-1:0]   hall_pending;
  logic [PEND_W-1:0]   car_pending;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Percentage of cycles in which the sender holds off / the receiver stalls.
  int unsigned send_gap_pct   = 37;
  int unsigned recv_stall_pct = 81;
  int unsigned fail_count     = 0;

  // Shadow copy of the controller: call sets, car position, sweep direction,
  // mode and tick counter, plus the two timing registers.
  floor_mask_t        hall_set;
  floor_mask_t        car_set;
  logic [FLOOR_W-1:0] pos_floor;
  logic               heading_down;
  mode_t              lift_mode;
  logic [TICK_W-1:0]  ticks;
  logic [TICK_W-1:0]  move_cfg;
  logic [TICK_W-1:0]  dwell_cfg;

  // Car status words still owed by the block, oldest first.
  result_t status_due_q[$];

  elevator_collective_controller_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .hall_floor    (hall_floor),
    .boarding_dest (boarding_dest),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .car_floor     (car_floor),
    .going_down    (going_down),
    .car_mode      (car_mode),
    .arrived       (arrived),
    .hall_pending  (hall_pending),
    .car_pending   (car_pending),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk = ~clk;

  // Safety net: end the run if the block hangs somewhere.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // One-hot mask for a floor; floors outside the building give nothing.
  function automatic floor_mask_t mask_of(int f);
    if (f < 1 || f > FLOOR_COUNT) return '0;
    return floor_mask_t'(1 << (f - 1));
  endfunction

  // Sweep rule: keep heading while calls lie ahead, else reverse; always turn
  // round at the bottom and top floors.
  function automatic logic sweep_down();
    floor_mask_t pending;
    floor_mask_t below_m;
    floor_mask_t upto_m;
    int          fl;
    fl      = pos_floor;
    pending = hall_set | car_set;
    below_m = floor_mask_t'((1 << (fl - 1)) - 1);
    upto_m  = floor_mask_t'((1 << fl) - 1);
    if (fl <= 1 && heading_down) return 1'b0;
    if (fl >= FLOOR_COUNT && !heading_down) return 1'b1;
    if (!heading_down) return ((pending & ~upto_m) == '0);
    return ((pending & below_m) != '0);
  endfunction

  // Advance the shadow controller by one event and return the status word
  // that the block must report for it.
  function automatic result_t lift_step(logic rq, logic [FLOOR_W-1:0] hf,
                                        logic [FLOOR_W-1:0] bd);
    floor_mask_t call_m;
    floor_mask_t here;
    logic        stop_now;
    result_t     r;
    call_m   = rq ? mask_of(hf) : '0;
    stop_now = 1'b0;
    case (lift_mode)
      MODE_MOVING: begin
        // Record the call first; every event, call or tick, counts as a tick.
        hall_set = hall_set | call_m;
        ticks    = ticks + 1'b1;
        if (ticks == move_cfg) begin
          ticks        = '0;
          heading_down = sweep_down();
          if (heading_down) begin
            if (pos_floor > 1) pos_floor = pos_floor - 1'b1;
          end else if (pos_floor < FLOOR_COUNT) begin
            pos_floor = pos_floor + 1'b1;
          end
          here = mask_of(pos_floor);
          if (((hall_set | car_set) & here) != '0) begin
            // Serve the floor; a boarding passenger adds a car call.
            lift_mode = MODE_STOPPED;
            car_set   = car_set & ~here;
            if ((hall_set & here) != '0) begin
              hall_set = hall_set & ~here;
              car_set  = car_set | mask_of(bd);
            end
            ticks    = '0;
            stop_now = 1'b1;
          end
        end
      end
      MODE_STOPPED: begin
        if (rq) begin
          if (hf != pos_floor) hall_set = hall_set | call_m;
        end else if (ticks == dwell_cfg) begin
          heading_down = sweep_down();
          lift_mode    = ((hall_set | car_set) != '0) ? MODE_MOVING : MODE_IDLE;
          ticks        = '0;
        end else begin
          ticks = ticks + 1'b1;
        end
      end
      default: begin
        lift_mode = MODE_IDLE;
        if (call_m != '0 && hf != pos_floor) begin
          hall_set     = hall_set | call_m;
          heading_down = sweep_down();
          lift_mode    = MODE_MOVING;
          ticks        = '0;
        end
      end
    endcase
    r.car_floor    = pos_floor;
    r.going_down   = heading_down;
    r.car_mode     = lift_mode;
    r.arrived      = stop_now;
    r.hall_pending = PEND_W'($countones(hall_set));
    r.car_pending  = PEND_W'($countones(car_set));
    return r;
  endfunction

  task automatic check_field(string what, logic [DATA_W-1:0] want,
                             logic [DATA_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Offer one word; hold it steady until the block takes it, then log the
  // status it must produce. Valid is decided before stall is looked at.
  task automatic send_word(logic rq, logic [FLOOR_W-1:0] hf, logic [FLOOR_W-1:0] bd);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= rq;
    hall_floor    <= hf;
    boarding_dest <= bd;
    do @(posedge clk); while (in_stall);
    status_due_q.push_back(lift_step(rq, hf, bd));
  endtask

  // Drop valid and wait until every owed status word has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One APB transfer, setup then access; psel stays up for a following one.
  task automatic apb_xfer(logic wr, logic idx, logic [TICK_W-1:0] val,
                          output logic [DATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    // Junk in the upper bits: only the low byte is kept.
    pwdata  <= {DATA_W'($urandom)} & ~DATA_W'(8'hFF) | DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
  endtask

  // Load both timing registers once idle, then read them back.
  task automatic set_timing(logic [TICK_W-1:0] mv, logic [TICK_W-1:0] dw);
    logic [DATA_W-1:0] rd;
    settle();
    apb_xfer(1'b1, REG_MOVE_TICKS, mv, rd);
    apb_xfer(1'b1, REG_DWELL_TICKS, dw, rd);
    move_cfg  = mv;
    dwell_cfg = dw;
    apb_xfer(1'b0, REG_MOVE_TICKS, '0, rd);
    check_field("move_ticks readback", DATA_W'(mv), DATA_W'(rd[TICK_W-1:0]));
    apb_xfer(1'b0, REG_DWELL_TICKS, '0, rd);
    check_field("dwell_ticks readback", DATA_W'(dw), DATA_W'(rd[TICK_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Short scripted trip with one-tick travel and dwell: calls at the car's
  // own floor, floors outside the building, a passenger heading for the
  // floor they board at, a turn at the top floor and a return to idle at
  // the bottom one.
  task automatic test_scripted_trip();
    set_timing(8'd1, 8'd1);
    send_word(1'b0, 3'd1, 3'd1);  // tick while idle
    send_word(1'b1, 3'd1, 3'd2);  // call at own floor while idle
    send_word(1'b1, 3'd0, 3'd3);  // floor 0: nothing recorded
    send_word(1'b1, 3'd7, 3'd4);  // floor 7: nothing recorded
    send_word(1'b1, 3'd5, 3'd0);  // start up towards 5
    send_word(1'b1, 3'd6, 3'd5);  // bad floor still counts as a tick
    send_word(1'b1, 3'd3, 3'd1);  // stop at 3, passenger for 1
    send_word(1'b1, 3'd3, 3'd2);  // own floor while stopped: ignored
    send_word(1'b1, 3'd4, 3'd2);  // record 4 while stopped
    send_word(1'b0, 3'd0, 3'd0);
    send_word(1'b0, 3'd0, 3'd0);  // dwell over, carry on up
    send_word(1'b0, 3'd4, 3'd4);  // stop at 4, passenger for 4
    send_word(1'b0, 3'd0, 3'd0);
    send_word(1'b0, 3'd0, 3'd0);
    send_word(1'b0, 3'd0, 3'd7);  // stop at 5, destination out of range
    send_word(1'b0, 3'd0, 3'd0);
    send_word(1'b0, 3'd0, 3'd0);  // turn round at the top
    for (int i = 0; i < 8; i++) send_word(1'b0, 3'd7, 3'd6);
  endtask

  // Register extremes: zero travel and dwell (wrap after 256 ticks, leave on
  // the first tick), then the longest settings.
  task automatic test_timing_extremes();
    set_timing(8'd0, 8'd0);
    send_word(1'b1, 3'd2, 3'd3);
    for (int i = 0; i < 262; i++) send_word(1'b0, 3'($urandom_range(7)), 3'd3);
    set_timing(8'd255, 8'd255);
    for (int i = 0; i < 530; i++) begin
      if (i % 60 == 0)
        send_word(1'b1, 3'($urandom_range(FLOOR_COUNT, 1)),
                  3'($urandom_range(FLOOR_COUNT, 1)));
      else
        send_word(1'b0, 3'($urandom_range(7)), 3'($urandom_range(FLOOR_COUNT, 1)));
    end
  endtask

  // Random traffic: mostly ticks and in-range calls with sensible
  // destinations, a sprinkling of bad floors, and the odd full drain.
  task automatic test_random_traffic(int unsigned gap, int unsigned stall, int n);
    int          pick;
    logic        rq;
    logic [2:0]  hf;
    logic [2:0]  bd;
    settle();
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (i == 0 || i == n / 2)
        set_timing(8'($urandom_range(4, 1)), 8'($urandom_range(4, 1)));
      pick = $urandom_range(99);
      rq   = (pick < 28);
      hf   = (pick < 25) ? 3'($urandom_range(FLOOR_COUNT, 1)) : 3'($urandom_range(7));
      bd   = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                      : 3'($urandom_range(FLOOR_COUNT, 1));
      send_word(rq, hf, bd);
      if ($urandom_range(199) == 0) settle();
    end
  endtask

  // Compare each status word against the oldest owed one; stall at random.
  always @(posedge clk) begin : check_status
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (status_due_q.size() == 0) begin
        fail_count++;
        $display("%0t ns: status word with none owed, expected nothing, got %h", $time,
                 {car_floor, going_down, car_mode, arrived, hall_pending, car_pending});
      end else begin
        want = status_due_q.pop_front();
        check_field("car_floor", DATA_W'(want.car_floor), DATA_W'(car_floor));
        check_field("going_down", DATA_W'(want.going_down), DATA_W'(going_down));
        check_field("car_mode", DATA_W'(want.car_mode), DATA_W'(car_mode));
        check_field("arrived", DATA_W'(want.arrived), DATA_W'(arrived));
        check_field("hall_pending", DATA_W'(want.hall_pending), DATA_W'(hall_pending));
        check_field("car_pending", DATA_W'(want.car_pending), DATA_W'(car_pending));
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    // Shadow state at reset: no calls, floor 1, heading up, idle.
    hall_set     = '0;
    car_set      = '0;
    pos_floor    = FLOOR_W'(1);
    heading_down = 1'b0;
    lift_mode    = MODE_IDLE;
    ticks        = '0;
    move_cfg     = MOVE_TICKS_RST;
    dwell_cfg    = DWELL_TICKS_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_scripted_trip();
    test_timing_extremes();
    test_random_traffic(37, 81, 360);
    test_random_traffic(81, 37, 360);
    test_random_traffic(0, 0, 360);

    // Wait out the last status words, then allow for the block's registered output.
    settle();
    if (status_due_q.size() != 0) fail_count++;
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/elcc_pkg.sv
sv/elcc_step.sv
sv/elevator_collective_controller_core.sv
sim/elevator_collective_controller_core_test.sv
